// ===== hdl/tpd_pkg.sv =====
// Shared types and constants for the touch press debounce block.
`timescale 1ns / 1ps
`default_nettype none

package tpd_pkg;

  // Default and widest width of the stored transition timestamp.
  localparam int STAMP_BITS_DEF = 32;
  localparam int STAMP_MAX_BITS = 64;

  // Field widths of the streams and the configuration port.
  localparam int NOW_BITS       = 32;
  localparam int STATE_BITS     = 3;
  localparam int CFG_DATA_BITS  = 16;
  localparam int CFG_ADDR_BITS  = 1;
  localparam int IN_TDATA_BITS  = 40;
  localparam int OUT_TDATA_BITS = 8;

  // Configuration register indexes.
  localparam logic [CFG_ADDR_BITS-1:0] REG_DEBOUNCE   = 1'd0;
  localparam logic [CFG_ADDR_BITS-1:0] REG_LONG_PRESS = 1'd1;

  // Reset values of the configuration registers.
  localparam logic [CFG_DATA_BITS-1:0] DEBOUNCE_RST   = 16'd10;
  localparam logic [CFG_DATA_BITS-1:0] LONG_PRESS_RST = 16'd1000;

  // Touch state encoding, shared by the state register and the result stream.
  typedef enum logic [STATE_BITS-1:0] {
    ST_RELEASED = 3'd0,
    ST_REL_WARN = 3'd1,
    ST_PRS_WARN = 3'd2,
    ST_PRESSED  = 3'd3,
    ST_LONG     = 3'd4
  } touch_state_t;

  // Outcome of evaluating one poll.
  typedef struct packed {
    touch_state_t next_state;
    logic         stamp_load;
  } step_res_t;

endpackage

`default_nettype wire

// ===== hdl/tpd_eval.sv =====
// Next-state logic of the touch state machine for one poll.
`timescale 1ns / 1ps
`default_nettype none

module tpd_eval #(
  parameter int STAMP_BITS = tpd_pkg::STAMP_BITS_DEF
) (
  input  wire logic                                pen_down,
  input  wire logic                                force_req,
  input  wire logic [tpd_pkg::STATE_BITS-1:0]      forced_state,
  input  wire tpd_pkg::touch_state_t               cur_state,
  input  wire logic [STAMP_BITS-1:0]               elapsed,
  input  wire logic [tpd_pkg::CFG_DATA_BITS-1:0]   debounce_ms,
  input  wire logic [tpd_pkg::CFG_DATA_BITS-1:0]   long_press_ms,
  output tpd_pkg::step_res_t                       res
);

  logic [tpd_pkg::STATE_BITS-1:0] eff_state;
  logic                           deb_done;
  logic                           long_done;

  // A forced state replaces the stored one before the poll is evaluated.
  assign eff_state = force_req ? forced_state : cur_state;

  // Elapsed time compares against the configured intervals.
  assign deb_done  = elapsed >= STAMP_BITS'(debounce_ms);
  assign long_done = elapsed >= STAMP_BITS'(long_press_ms);

  // Transitions; codes outside the encoding fall into the default arms.
  always_comb begin
    res.next_state = tpd_pkg::ST_RELEASED;
    res.stamp_load = 1'b0;
    if (pen_down) begin
      case (eff_state)
        tpd_pkg::ST_PRS_WARN: begin
          if (deb_done) begin
            res.next_state = tpd_pkg::ST_PRESSED;
            res.stamp_load = 1'b1;
          end else begin
            res.next_state = tpd_pkg::ST_PRS_WARN;
          end
        end
        tpd_pkg::ST_PRESSED: begin
          res.next_state = long_done ? tpd_pkg::ST_LONG : tpd_pkg::ST_PRESSED;
        end
        tpd_pkg::ST_LONG: begin
          res.next_state = tpd_pkg::ST_LONG;
        end
        default: begin
          res.next_state = tpd_pkg::ST_PRS_WARN;
          res.stamp_load = 1'b1;
        end
      endcase
    end else begin
      case (eff_state)
        tpd_pkg::ST_REL_WARN: begin
          res.next_state = deb_done ? tpd_pkg::ST_RELEASED : tpd_pkg::ST_REL_WARN;
        end
        tpd_pkg::ST_RELEASED: begin
          res.next_state = tpd_pkg::ST_RELEASED;
        end
        default: begin
          res.next_state = tpd_pkg::ST_REL_WARN;
          res.stamp_load = 1'b1;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hdl/touch_press_debounce_fsm.sv =====
// Top level of the touch press debounce and long-press detector.
//
// Usage: each request on the in_ stream is one poll of the touch panel, carrying
// the pen-down level, a millisecond timestamp and an optional forced state. For
// every poll exactly one result request leaves on the out_ stream with the touch
// state after that poll (released, release warning, press warning, pressed,
// long press).
// Each accepted poll is held in the input register and evaluated from there;
// its result is written to the output register. Throughput: one poll per cycle
// while out_tready stays high; the only recurrence is the state and stamp
// register update, a single timestamp subtraction and compare per cycle.
// Reset (rst_n low, synchronous) clears the pipeline valids, sets the state to
// released, the stamp to zero and the intervals to 10 ms and 1000 ms.
// When the receiver stalls, the result stays in the output register and the
// input register takes one more poll; in_tready drops until the result is taken.
// The user writes the configuration port only while idle; nothing enforces it.
`timescale 1ns / 1ps
`default_nettype none

module touch_press_debounce_fsm #(
  parameter int STAMP_BITS = tpd_pkg::STAMP_BITS_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  // Fields from bit 0: pen_down[0], now_ms[32:1], force_req[33],
  // forced_state[36:34], zero fill[39:37].
  input  wire logic [tpd_pkg::IN_TDATA_BITS-1:0]    in_tdata,
  input  wire logic                                 in_tvalid,
  output logic                                      in_tready,
  // Fields from bit 0: touch_state[2:0], zero fill[7:3].
  output logic [tpd_pkg::OUT_TDATA_BITS-1:0]        out_tdata,
  output logic                                      out_tvalid,
  input  wire logic                                 out_tready,
  input  wire logic                                 cfg_wr_en,
  input  wire logic [tpd_pkg::CFG_ADDR_BITS-1:0]    cfg_addr,
  input  wire logic [tpd_pkg::CFG_DATA_BITS-1:0]    cfg_wdata
);

  // Input register.
  logic                               s1_valid_r;
  logic                               s1_pen_r;
  logic [tpd_pkg::NOW_BITS-1:0]       s1_now_r;
  logic                               s1_force_r;
  logic [tpd_pkg::STATE_BITS-1:0]     s1_forced_r;

  // Machine state and configuration.
  tpd_pkg::touch_state_t              state_r;
  tpd_pkg::touch_state_t              state_nxt;
  logic [STAMP_BITS-1:0]              stamp_r;
  logic [STAMP_BITS-1:0]              stamp_nxt;
  logic [tpd_pkg::CFG_DATA_BITS-1:0]  debounce_r;
  logic [tpd_pkg::CFG_DATA_BITS-1:0]  long_press_r;

  // Output register.
  logic                               out_valid_r;
  logic [tpd_pkg::STATE_BITS-1:0]     out_state_r;

  logic                               s1_adv;
  logic [tpd_pkg::STAMP_MAX_BITS-1:0] now_wide;
  logic [STAMP_BITS-1:0]              now_stamp;
  logic [STAMP_BITS-1:0]              elapsed;
  tpd_pkg::step_res_t                 step_res;

  // Handshake: the input stage advances when the output register is free.
  assign s1_adv    = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_pen_r    <= in_tdata[0];
      s1_now_r    <= in_tdata[32:1];
      s1_force_r  <= in_tdata[33];
      s1_forced_r <= in_tdata[36:34];
    end
  end

  // Timestamp reduced to the stamp width and the wrapping elapsed time.
  assign now_wide  = {{(tpd_pkg::STAMP_MAX_BITS - tpd_pkg::NOW_BITS){1'b0}}, s1_now_r};
  assign now_stamp = now_wide[STAMP_BITS-1:0];
  assign elapsed   = now_stamp - stamp_r;

  tpd_eval #(
    .STAMP_BITS (STAMP_BITS)
  ) u_eval (
    .pen_down      (s1_pen_r),
    .force_req     (s1_force_r),
    .forced_state  (s1_forced_r),
    .cur_state     (state_r),
    .elapsed       (elapsed),
    .debounce_ms   (debounce_r),
    .long_press_ms (long_press_r),
    .res           (step_res)
  );

  // Next state and stamp, committed only when the poll advances.
  always_comb begin
    state_nxt = state_r;
    stamp_nxt = stamp_r;
    if (s1_adv) begin
      state_nxt = step_res.next_state;
      if (step_res.stamp_load) begin
        stamp_nxt = now_stamp;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tpd_pkg::ST_RELEASED;
      stamp_r <= '0;
    end else begin
      state_r <= state_nxt;
      stamp_r <= stamp_nxt;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r   <= tpd_pkg::DEBOUNCE_RST;
      long_press_r <= tpd_pkg::LONG_PRESS_RST;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        tpd_pkg::REG_DEBOUNCE:   debounce_r   <= cfg_wdata;
        tpd_pkg::REG_LONG_PRESS: long_press_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_state_r <= step_res.next_state;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(tpd_pkg::OUT_TDATA_BITS - tpd_pkg::STATE_BITS){1'b0}}, out_state_r};

  // The reported state is always a valid code, even after a forced load.
  a_state_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_state_r <= tpd_pkg::ST_LONG))
    else $error("touch state code out of range");

  // The result register carries the state just committed.
  a_out_matches: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> (out_tvalid && out_state_r == state_r))
    else $error("result differs from committed state");

  // The state and stamp change only when a poll is evaluated.
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_adv |=> ($stable(state_r) && $stable(stamp_r)))
    else $error("state changed without a poll");

  // A long press can only be entered with the pen down, from pressed or a forced state.
  a_long_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && step_res.next_state == tpd_pkg::ST_LONG && state_r != tpd_pkg::ST_LONG)
      |-> (s1_pen_r && (state_r == tpd_pkg::ST_PRESSED || s1_force_r)))
    else $error("long press entered from a wrong state");

endmodule

`default_nettype wire

// ===== bench/touch_press_debounce_fsm_test.sv =====
// Self-checking testbench for the touch press debounce and long-press detector.
`timescale 1ns / 1ps
`default_nettype none

module touch_press_debounce_fsm_test;
  import tpd_pkg::*;

  localparam int CLK_PERIOD  = 12;
  localparam int RESET_CYCLES = 6;
  localparam int PHASE_POLLS = 180;
  localparam int PHASE_COUNT = 8;
  localparam int HOLD_CYCLES = 60;
  localparam int DRAIN_LIMIT = 500;
  localparam logic PIN  = 1'b1;
  localparam logic FREE = 1'b0;

  // One step of the directed sequence: either a register write or a poll.
  typedef struct packed {
    logic                     is_cfg;
    logic [CFG_ADDR_BITS-1:0] addr;
    logic [CFG_DATA_BITS-1:0] value;
    logic                     pen;
    logic [NOW_BITS-1:0]      now;
    logic                     frc;
    logic [STATE_BITS-1:0]    fst;
    logic                     pinned;
    touch_state_t             pin;
  } dir_row_t;

  // A state typed into the directed sequence, carried with its poll.
  typedef struct packed {
    logic         pinned;
    touch_state_t val;
  } pin_t;

  logic                      clk;
  logic                      rst_n;
  logic [IN_TDATA_BITS-1:0]  in_tdata;
  logic                      in_tvalid;
  logic                      in_tready;
  logic [OUT_TDATA_BITS-1:0] out_tdata;
  logic                      out_tvalid;
  logic                      out_tready;
  logic                      cfg_wr_en;
  logic [CFG_ADDR_BITS-1:0]  cfg_addr;
  logic [CFG_DATA_BITS-1:0]  cfg_wdata;

  // Predictor copy of the block's state and intervals.
  logic [STATE_BITS-1:0]     pred_state = ST_RELEASED;
  logic [NOW_BITS-1:0]       pred_stamp = '0;
  logic [CFG_DATA_BITS-1:0]  debounce_ms;
  logic [CFG_DATA_BITS-1:0]  long_press_ms;

  touch_state_t state_q[$];
  pin_t         pin_q[$];
  dir_row_t     dir_rows[$];

  logic send_idle;
  logic recv_idle;
  logic hold_req;
  logic hold_done;
  int   fail_count = 0;

  touch_press_debounce_fsm DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #5_000_000;
    $display("FAIL touch_press_debounce_fsm");
    $finish;
  end

  // Applies one poll to the predicted state and returns the reported state.
  // A forced code of five to seven falls through to the "other state" branch.
  function automatic touch_state_t advance_touch(logic pen, logic [NOW_BITS-1:0] now,
                                                 logic frc, logic [STATE_BITS-1:0] fst);
    logic [NOW_BITS-1:0] elapsed;
    if (frc) pred_state = fst;
    elapsed = now - pred_stamp;
    if (pen) begin
      case (pred_state)
        ST_PRS_WARN: begin
          if (elapsed >= debounce_ms) begin
            pred_state = ST_PRESSED;
            pred_stamp = now;
          end
        end
        ST_PRESSED: begin
          if (elapsed >= long_press_ms) pred_state = ST_LONG;
        end
        ST_LONG: ;
        default: begin
          pred_state = ST_PRS_WARN;
          pred_stamp = now;
        end
      endcase
    end else begin
      case (pred_state)
        ST_REL_WARN: begin
          if (elapsed >= debounce_ms) pred_state = ST_RELEASED;
        end
        ST_RELEASED: ;
        default: begin
          pred_state = ST_REL_WARN;
          pred_stamp = now;
        end
      endcase
    end
    return touch_state_t'(pred_state);
  endfunction

  function automatic dir_row_t poll_row(logic pen, logic [NOW_BITS-1:0] now, logic frc,
                                        logic [STATE_BITS-1:0] fst, logic pinned,
                                        touch_state_t pin);
    dir_row_t r;
    r = '0;
    r.pen = pen;
    r.now = now;
    r.frc = frc;
    r.fst = fst;
    r.pinned = pinned;
    r.pin = pin;
    return r;
  endfunction

  function automatic dir_row_t cfg_row(logic [CFG_ADDR_BITS-1:0] idx,
                                       logic [CFG_DATA_BITS-1:0] value);
    dir_row_t r;
    r = '0;
    r.is_cfg = 1'b1;
    r.addr = idx;
    r.value = value;
    return r;
  endfunction

  // Offers one poll request and returns at the falling edge after it is taken.
  task automatic send_poll(input logic pen, input logic [NOW_BITS-1:0] now, input logic frc,
                           input logic [STATE_BITS-1:0] fst, input logic pinned,
                           input touch_state_t pin);
    int   gap;
    pin_t tag;
    gap = send_idle ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    tag.pinned = pinned;
    tag.val = pin;
    pin_q.push_back(tag);
    in_tdata = {3'b000, fst, frc, now, pen};
    in_tvalid = 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // Waits until every outstanding poll has reported, then writes one register.
  task automatic write_reg(input logic [CFG_ADDR_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] value);
    int waited;
    waited = 0;
    in_tvalid = 1'b0;
    while (state_q.size() != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    repeat (3) @(negedge clk);
    cfg_addr = idx;
    cfg_wdata = value;
    cfg_wr_en = 1'b1;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    if (idx == REG_DEBOUNCE) debounce_ms = value;
    else long_press_ms = value;
  endtask

  // Random polls: pen held in runs with a running timestamp, plus bounces,
  // clock jumps and forced states as noise.
  task automatic run_phase(input int n_polls);
    logic [NOW_BITS-1:0]   now;
    logic                  pen;
    logic                  frc;
    logic [STATE_BITS-1:0] fst;
    int                    run_left;
    int                    step_max;
    now = $urandom;
    pen = 1'($urandom_range(0, 1));
    run_left = 0;
    step_max = ((debounce_ms > long_press_ms) ? debounce_ms : long_press_ms) / 3 + 2;
    for (int i = 0; i < n_polls; i++) begin
      if (run_left == 0) begin
        pen = ~pen;
        run_left = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(1, 14);
      end
      run_left--;
      if ($urandom_range(0, 31) == 0) now = $urandom;
      else if ($urandom_range(0, 7) == 0) now = now + NOW_BITS'(debounce_ms);
      else now = now + $urandom_range(0, step_max);
      frc = ($urandom_range(0, 19) == 0);
      fst = STATE_BITS'($urandom_range(0, 7));
      send_poll(pen, now, frc, fst, FREE, ST_RELEASED);
    end
  endtask

  // Predicts on every accepted poll and checks every accepted result.
  always @(posedge clk) begin
    pin_t         tag;
    touch_state_t want;
    if (rst_n && in_tvalid && in_tready) begin
      tag = pin_q.pop_front();
      want = advance_touch(in_tdata[0], in_tdata[32:1], in_tdata[33], in_tdata[36:34]);
      state_q.push_back(tag.pinned ? tag.val : want);
    end
    if (rst_n && out_tvalid && out_tready) begin
      if (state_q.size() == 0) begin
        $error("touch_state: no result expected, got %0d", out_tdata[STATE_BITS-1:0]);
        fail_count++;
      end else begin
        want = state_q.pop_front();
        if (out_tdata[STATE_BITS-1:0] !== want) begin
          $error("touch_state: expected %0d, got %0d", want, out_tdata[STATE_BITS-1:0]);
          fail_count++;
        end
      end
    end
  end

  // Result side: a random stall before each result, or one long hold-off on request.
  initial begin
    int stall;
    out_tready = 1'b0;
    hold_done = 1'b0;
    @(negedge clk);
    while (!rst_n) @(negedge clk);
    forever begin
      stall = recv_idle ? $urandom_range(0, 3) : 0;
      if (hold_req && !hold_done) begin
        stall = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (stall > 0) begin
        out_tready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready = 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      @(negedge clk);
    end
  end

  initial begin
    int                       waited;
    logic                     missing;
    logic [CFG_DATA_BITS-1:0] deb;
    logic [CFG_DATA_BITS-1:0] lng;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    cfg_wr_en = 1'b0;
    cfg_addr = REG_DEBOUNCE;
    cfg_wdata = '0;
    send_idle = 1'b1;
    recv_idle = 1'b1;
    hold_req = 1'b0;
    missing = 1'b0;
    debounce_ms = DEBOUNCE_RST;
    long_press_ms = LONG_PRESS_RST;

    // Directed sequence with the reset intervals of 10 ms and 1000 ms.
    dir_rows.push_back(poll_row(1'b0, 32'd0, 1'b0, 3'd0, PIN, ST_RELEASED));
    dir_rows.push_back(poll_row(1'b1, 32'd100, 1'b0, 3'd0, PIN, ST_PRS_WARN));
    dir_rows.push_back(poll_row(1'b1, 32'd109, 1'b0, 3'd0, FREE, ST_RELEASED));
    dir_rows.push_back(poll_row(1'b1, 32'd110, 1'b0, 3'd0, PIN, ST_PRESSED));
    dir_rows.push_back(poll_row(1'b1, 32'd1109, 1'b0, 3'd0, FREE, ST_RELEASED));
    dir_rows.push_back(poll_row(1'b1, 32'd1110, 1'b0, 3'd0, PIN, ST_LONG));
    dir_rows.push_back(poll_row(1'b1, 32'hFFFF_FFFF, 1'b0, 3'd0, PIN, ST_LONG));
    dir_rows.push_back(poll_row(1'b0, 32'hFFFF_FFFF, 1'b0, 3'd0, PIN, ST_REL_WARN));
    // Elapsed time across the timestamp wrap.
    dir_rows.push_back(poll_row(1'b0, 32'd8, 1'b0, 3'd0, FREE, ST_RELEASED));
    dir_rows.push_back(poll_row(1'b0, 32'd9, 1'b0, 3'd0, PIN, ST_RELEASED));
    // Forced states, including the codes outside the encoding.
    dir_rows.push_back(poll_row(1'b1, 32'd20, 1'b1, 3'd7, PIN, ST_PRS_WARN));
    dir_rows.push_back(poll_row(1'b0, 32'd21, 1'b1, 3'd5, PIN, ST_REL_WARN));
    dir_rows.push_back(poll_row(1'b1, 32'd22, 1'b1, 3'd6, PIN, ST_PRS_WARN));
    dir_rows.push_back(poll_row(1'b1, 32'd1021, 1'b1, ST_PRESSED, FREE, ST_RELEASED));
    dir_rows.push_back(poll_row(1'b1, 32'd1022, 1'b1, ST_PRESSED, FREE, ST_RELEASED));
    dir_rows.push_back(poll_row(1'b0, 32'hAAAA_AAAA, 1'b1, ST_LONG, PIN, ST_REL_WARN));
    dir_rows.push_back(poll_row(1'b1, 32'h5555_5555, 1'b1, ST_REL_WARN, PIN, ST_PRS_WARN));
    dir_rows.push_back(poll_row(1'b0, 32'h5555_5556, 1'b1, ST_PRS_WARN, PIN, ST_REL_WARN));
    dir_rows.push_back(poll_row(1'b1, 32'd0, 1'b1, ST_RELEASED, PIN, ST_PRS_WARN));
    // Zero intervals: every transition fires on the first poll that checks it.
    dir_rows.push_back(cfg_row(REG_DEBOUNCE, 16'd0));
    dir_rows.push_back(cfg_row(REG_LONG_PRESS, 16'd0));
    dir_rows.push_back(poll_row(1'b1, 32'd0, 1'b0, 3'd0, PIN, ST_PRESSED));
    dir_rows.push_back(poll_row(1'b1, 32'd0, 1'b0, 3'd0, PIN, ST_LONG));
    dir_rows.push_back(poll_row(1'b0, 32'd5, 1'b0, 3'd0, PIN, ST_REL_WARN));
    dir_rows.push_back(poll_row(1'b0, 32'd5, 1'b0, 3'd0, PIN, ST_RELEASED));

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) begin
        write_reg(dir_rows[i].addr, dir_rows[i].value);
      end else begin
        send_poll(dir_rows[i].pen, dir_rows[i].now, dir_rows[i].frc, dir_rows[i].fst,
                  dir_rows[i].pinned, dir_rows[i].pin);
      end
    end

    // Random phases over a spread of interval settings, extremes included.
    for (int p = 0; p < PHASE_COUNT; p++) begin
      case (p)
        0: begin deb = 16'd0;     lng = 16'd0;     end
        1: begin deb = 16'hFFFF;  lng = 16'hFFFF;  end
        2: begin deb = 16'd0;     lng = 16'hFFFF;  end
        3: begin deb = 16'hFFFF;  lng = 16'd0;     end
        4: begin deb = 16'd1;     lng = 16'd2;     end
        7: begin deb = DEBOUNCE_RST; lng = LONG_PRESS_RST; end
        default: begin
          deb = CFG_DATA_BITS'($urandom_range(0, 200));
          lng = CFG_DATA_BITS'($urandom_range(0, 3000));
        end
      endcase
      write_reg(REG_DEBOUNCE, deb);
      write_reg(REG_LONG_PRESS, lng);
      // One phase runs without gaps on either side; one has the receiver
      // hold off long enough to back up the input.
      send_idle = (p != 5);
      recv_idle = (p != 5);
      if (p == 2) hold_req = 1'b1;
      run_phase(PHASE_POLLS);
    end

    // Drain the remaining results.
    in_tvalid = 1'b0;
    waited = 0;
    while (state_q.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (4) @(posedge clk);
    if (state_q.size() != 0) begin
      $error("touch_state: %0d expected results never arrived", state_q.size());
      missing = 1'b1;
    end
    if (fail_count == 0 && !missing) begin
      $display("PASS touch_press_debounce_fsm");
    end else begin
      $display("FAIL touch_press_debounce_fsm");
    end
    $finish;
  end

endmodule

`default_nettype wire
